### rtl/obot_pkg.sv
// Shared types, trig table and helpers for the oriented box overlap test.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package obot_pkg;

    // Per-stage advance enables for the corner generator.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } obot_ctl_t;

    localparam int ANGLE_W   = 9;
    localparam int EXTENT_W  = 14;
    localparam int SIN_MAG_W = 17;

    localparam logic [SIN_MAG_W-1:0] SIN_Q16 [91] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
        17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
        17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
        17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
        17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
        17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
        17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
        17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
        17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
        17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
        17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
        17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
        17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // Magnitude of sin(d) in Q16 for d in 0..359, folded by quadrant.
    function automatic logic [SIN_MAG_W-1:0] sin_mag(input logic [ANGLE_W-1:0] d);
        logic [ANGLE_W-1:0] idx;
        begin
            if (d < 9'd90)
            begin
                idx = d;
            end
            else if (d < 9'd180)
            begin
                idx = 9'd180 - d;
            end
            else if (d < 9'd270)
            begin
                idx = d - 9'd180;
            end
            else
            begin
                idx = 9'd360 - d;
            end
            return SIN_Q16[idx[6:0]];
        end
    endfunction

    function automatic logic sin_neg(input logic [ANGLE_W-1:0] d);
        return d >= 9'd180;
    endfunction

endpackage

### rtl/obot_if.sv
// Request and result channel interfaces of the oriented box overlap test.
// Depends on obot_pkg for field widths.
`timescale 1ns / 1ps

interface obot_in_if #(parameter int COORD_WIDTH = 16);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0]         a_center_x;
    logic signed [COORD_WIDTH-1:0]         a_center_y;
    logic [obot_pkg::EXTENT_W-1:0]         a_half_width;
    logic [obot_pkg::EXTENT_W-1:0]         a_half_height;
    logic [obot_pkg::ANGLE_W-1:0]          a_angle_deg;
    logic signed [COORD_WIDTH-1:0]         b_center_x;
    logic signed [COORD_WIDTH-1:0]         b_center_y;
    logic [obot_pkg::EXTENT_W-1:0]         b_half_width;
    logic [obot_pkg::EXTENT_W-1:0]         b_half_height;
    logic [obot_pkg::ANGLE_W-1:0]          b_angle_deg;

    modport source (output valid, a_center_x, a_center_y, a_half_width, a_half_height,
                    a_angle_deg, b_center_x, b_center_y, b_half_width, b_half_height,
                    b_angle_deg, input ready);
    modport sink   (input valid, a_center_x, a_center_y, a_half_width, a_half_height,
                    a_angle_deg, b_center_x, b_center_y, b_half_width, b_half_height,
                    b_angle_deg, output ready);
endinterface

interface obot_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink   (input valid, overlap, output ready);
endinterface

### rtl/obot_corner.sv
// Three-stage corner generator for one rotated box: trig lookup, products, corners.
// Depends on obot_pkg (sine table, stage enable struct).
`timescale 1ns / 1ps

module obot_corner #(
    parameter int COORD_WIDTH    = 16,
    parameter int TRIG_FRAC_BITS = 14,
    parameter int CRW            = 19
) (
    input  logic                                  clk,
    input  obot_pkg::obot_ctl_t                   ctl,
    input  logic signed [COORD_WIDTH-1:0]         center_x,
    input  logic signed [COORD_WIDTH-1:0]         center_y,
    input  logic [obot_pkg::EXTENT_W-1:0]         half_width,
    input  logic [obot_pkg::EXTENT_W-1:0]         half_height,
    input  logic [obot_pkg::ANGLE_W-1:0]          angle_deg,
    output logic signed [CRW-1:0]                 corner_x [4],
    output logic signed [CRW-1:0]                 corner_y [4]
);

    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int MW  = obot_pkg::EXTENT_W + 1 + TW;
    localparam int PW  = MW + 1;
    localparam int SH  = 16 - TRIG_FRAC_BITS;
    localparam int SCW = obot_pkg::SIN_MAG_W + 2;
    // Sign patterns per corner: bit set means subtract that product.
    localparam logic [3:0] X_WC_NEG = 4'b0011;
    localparam logic [3:0] X_HS_NEG = 4'b0110;
    localparam logic [3:0] Y_WS_NEG = 4'b0011;
    localparam logic [3:0] Y_HC_NEG = 4'b1001;

    // Stage 1: reduced angle and trig values
    logic [obot_pkg::ANGLE_W-1:0] d, cd;
    logic signed [TW-1:0] sin_next, cos_next;
    logic signed [TW-1:0] sin_reg, cos_reg;
    logic signed [COORD_WIDTH-1:0] cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic [obot_pkg::EXTENT_W-1:0] w1_reg, h1_reg;

    function automatic logic signed [TW-1:0] scale_trig(input logic [obot_pkg::ANGLE_W-1:0] a);
        logic [SCW-1:0] m;
        begin
            m = ({2'b00, obot_pkg::sin_mag(a)} << 1) + (SCW'(1) << SH);
            m = m >> (SH + 1);
            if (obot_pkg::sin_neg(a))
            begin
                return -$signed(TW'(m));
            end
            return $signed(TW'(m));
        end
    endfunction

    always_comb
    begin
        d  = (angle_deg >= 9'd360) ? angle_deg - 9'd360 : angle_deg;
        cd = (d >= 9'd270) ? d - 9'd270 : d + 9'd90;
        sin_next = scale_trig(d);
        cos_next = scale_trig(cd);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
            cx1_reg <= center_x;
            cy1_reg <= center_y;
            w1_reg  <= half_width;
            h1_reg  <= half_height;
        end
    end

    // Stage 2: the four products
    logic signed [MW-1:0] wc_reg, ws_reg, hc_reg, hs_reg;
    logic signed [obot_pkg::EXTENT_W:0] ws1, hs1;

    assign ws1 = $signed({1'b0, w1_reg});
    assign hs1 = $signed({1'b0, h1_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.en2)
        begin
            wc_reg  <= ws1 * cos_reg;
            ws_reg  <= ws1 * sin_reg;
            hc_reg  <= hs1 * cos_reg;
            hs_reg  <= hs1 * sin_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
        end
    end

    // Stage 3: rounded offsets added to the center
    logic signed [PW-1:0] sum_x [4], sum_y [4];
    logic signed [CRW-1:0] cx_next [4], cy_next [4];
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] wc_e, ws_e, hc_e, hs_e;

    always_comb
    begin
        half = PW'(1) <<< (TRIG_FRAC_BITS - 1);
        wc_e = PW'(wc_reg);
        ws_e = PW'(ws_reg);
        hc_e = PW'(hc_reg);
        hs_e = PW'(hs_reg);
        for (int i = 0; i < 4; i++)
        begin
            sum_x[i] = (X_WC_NEG[i] ? -wc_e : wc_e) + (X_HS_NEG[i] ? -hs_e : hs_e) + half;
            sum_y[i] = (Y_WS_NEG[i] ? -ws_e : ws_e) + (Y_HC_NEG[i] ? -hc_e : hc_e) + half;
            cx_next[i] = CRW'(cx2_reg) + CRW'(sum_x[i] >>> TRIG_FRAC_BITS);
            cy_next[i] = CRW'(cy2_reg) + CRW'(sum_y[i] >>> TRIG_FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en3)
        begin
            corner_x <= cx_next;
            corner_y <= cy_next;
        end
    end

endmodule

### rtl/oriented_box_overlap_test.sv
// Top level of the oriented box overlap test: six-stage pipeline with per-stage valids.
// Depends on obot_pkg, obot_if and obot_corner.
`timescale 1ns / 1ps
//
// Usage:
//   boxes  - request channel: two rotated boxes (center, half extents, angle in
//            whole degrees). A request is taken when valid and ready are high.
//   result - one overlap bit per request, in request order.
// Pipeline: a request reaches result valid through the trig lookup, product,
//   corner, axis, projection and min/max compare stages.
// Throughput: one request per cycle while the result side is ready; the 128
//   projection multipliers of the fifth stage are fully parallel, so no stage iterates.
// Stall: each stage holds its data when the stage after it is full and
//   blocked; bubbles still collapse, so ready stays high while a result waits
//   as long as any stage is empty.
// Reset: clears all stage valids; no request or result is in flight after it.
//
module oriented_box_overlap_test #(
    parameter int COORD_WIDTH    = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    obot_in_if.sink    boxes,
    obot_out_if.source result
);

    localparam int RW  = 18;
    localparam int CRW = ((COORD_WIDTH > RW) ? COORD_WIDTH : RW) + 1;
    localparam int AW  = CRW + 2;
    localparam int PRW = CRW + AW + 1;
    localparam int NST = 6;

    logic [NST:1] v_reg;
    logic [NST+1:1] en;

    always_comb
    begin
        en[NST+1] = result.ready;
        for (int k = NST; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign boxes.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= boxes.valid;
            end
            for (int k = 2; k <= NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    obot_pkg::obot_ctl_t ctl;
    assign ctl.en1 = en[1];
    assign ctl.en2 = en[2];
    assign ctl.en3 = en[3];

    logic signed [CRW-1:0] ax_c [4], ay_c [4], bx_c [4], by_c [4];

    obot_corner #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .CRW(CRW)) u_box_a (
        .clk(clk), .ctl(ctl),
        .center_x(boxes.a_center_x), .center_y(boxes.a_center_y),
        .half_width(boxes.a_half_width), .half_height(boxes.a_half_height),
        .angle_deg(boxes.a_angle_deg), .corner_x(ax_c), .corner_y(ay_c)
    );

    obot_corner #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS), .CRW(CRW)) u_box_b (
        .clk(clk), .ctl(ctl),
        .center_x(boxes.b_center_x), .center_y(boxes.b_center_y),
        .half_width(boxes.b_half_width), .half_height(boxes.b_half_height),
        .angle_deg(boxes.b_angle_deg), .corner_x(bx_c), .corner_y(by_c)
    );

    // Stage 4: edge normals of both boxes; carry corners along
    logic signed [AW-1:0] axis_x_reg [8], axis_y_reg [8];
    logic signed [CRW-1:0] cx_reg [2][4], cy_reg [2][4];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 4; i++)
            begin
                axis_x_reg[i]   <= AW'(ay_c[i]) - AW'(ay_c[(i+1)%4]);
                axis_y_reg[i]   <= AW'(ax_c[(i+1)%4]) - AW'(ax_c[i]);
                axis_x_reg[i+4] <= AW'(by_c[i]) - AW'(by_c[(i+1)%4]);
                axis_y_reg[i+4] <= AW'(bx_c[(i+1)%4]) - AW'(bx_c[i]);
                cx_reg[0][i] <= ax_c[i];
                cy_reg[0][i] <= ay_c[i];
                cx_reg[1][i] <= bx_c[i];
                cy_reg[1][i] <= by_c[i];
            end
        end
    end

    // Stage 5: project every corner onto every axis
    logic signed [PRW-1:0] proj_reg [8][2][4];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int k = 0; k < 8; k++)
            begin
                for (int b = 0; b < 2; b++)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        proj_reg[k][b][i] <= PRW'(cx_reg[b][i] * axis_x_reg[k])
                                           + PRW'(cy_reg[b][i] * axis_y_reg[k]);
                    end
                end
            end
        end
    end

    // Stage 6: interval extents per axis, separation test
    logic signed [PRW-1:0] lo [8][2], hi [8][2];
    logic [7:0] sep;
    logic overlap_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            for (int b = 0; b < 2; b++)
            begin
                lo[k][b] = proj_reg[k][b][0];
                hi[k][b] = proj_reg[k][b][0];
                for (int i = 1; i < 4; i++)
                begin
                    if (proj_reg[k][b][i] < lo[k][b])
                    begin
                        lo[k][b] = proj_reg[k][b][i];
                    end
                    if (proj_reg[k][b][i] > hi[k][b])
                    begin
                        hi[k][b] = proj_reg[k][b][i];
                    end
                end
            end
            sep[k] = !(hi[k][0] >= lo[k][1] && hi[k][1] >= lo[k][0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            overlap_reg <= ~|sep;
        end
    end

    assign result.valid   = v_reg[NST];
    assign result.overlap = overlap_reg;

endmodule

### dv/testbench.sv
// Self-checking testbench for the oriented box overlap test: random and directed
// box pairs, overlap bit predicted by an in-bench separating axis model.
// Depends on obot_pkg, obot_if and the oriented_box_overlap_test RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CW = 16;
    localparam int TFB = 14;
    localparam int EW = obot_pkg::EXTENT_W;
    localparam int AGW = obot_pkg::ANGLE_W;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [EW-1:0] hw;
        logic [EW-1:0] hh;
        logic [AGW-1:0] ang;
    } box_t;

    logic clk;
    logic rst_n;
    obot_in_if #(.COORD_WIDTH(CW)) boxes();
    obot_out_if result();

    oriented_box_overlap_test #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TFB)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .boxes(boxes),
        .result(result)
    );

    bit overlap_q[$];
    int errors;
    int idle_cycles;
    bit hold_result;
    int hold_cycles;
    int stall_left;
    int quarter_tab[91] = '{
        0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
        11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
        22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
        32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
        42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
        50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
        56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
        61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
        64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
        65536
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint trig_sin(int d);
        int q;
        int r;
        longint t;
        begin
            q = d / 90;
            r = d % 90;
            if (q == 1 || q == 3)
            begin
                r = 90 - r;
            end
            t = (quarter_tab[r] + (1 << (16 - TFB - 1))) >>> (16 - TFB);
            return (q >= 2) ? -t : t;
        end
    endfunction

    function automatic void box_corners(input box_t b, output longint px[4],
                                        output longint py[4]);
        longint ox[4];
        longint oy[4];
        longint s;
        longint c;
        longint w;
        longint h;
        int d;
        begin
            d = b.ang;
            if (d >= 360)
            begin
                d -= 360;
            end
            s = trig_sin(d);
            c = trig_sin((d + 90) % 360);
            w = b.hw;
            h = b.hh;
            ox = '{-w, -w, w, w};
            oy = '{-h, h, h, -h};
            for (int i = 0; i < 4; i++)
            begin
                // arithmetic shift floors, which gives round half up
                px[i] = longint'(b.cx) + ((ox[i] * c - oy[i] * s + (1 << (TFB - 1))) >>> TFB);
                py[i] = longint'(b.cy) + ((ox[i] * s + oy[i] * c + (1 << (TFB - 1))) >>> TFB);
            end
        end
    endfunction

    function automatic bit boxes_overlap(box_t a, box_t b);
        longint xa[4];
        longint ya[4];
        longint xb[4];
        longint yb[4];
        longint ex;
        longint ey;
        longint p;
        longint lo1;
        longint hi1;
        longint lo2;
        longint hi2;
        begin
            box_corners(a, xa, ya);
            box_corners(b, xb, yb);
            for (int k = 0; k < 2; k++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ex = k ? xb[(i + 1) & 3] - xb[i] : xa[(i + 1) & 3] - xa[i];
                    ey = k ? yb[(i + 1) & 3] - yb[i] : ya[(i + 1) & 3] - ya[i];
                    for (int j = 0; j < 4; j++)
                    begin
                        p = xa[j] * -ey + ya[j] * ex;
                        if (j == 0 || p < lo1) lo1 = p;
                        if (j == 0 || p > hi1) hi1 = p;
                        p = xb[j] * -ey + yb[j] * ex;
                        if (j == 0 || p < lo2) lo2 = p;
                        if (j == 0 || p > hi2) hi2 = p;
                    end
                    if (hi1 < lo2 || hi2 < lo1)
                    begin
                        return 1'b0;
                    end
                end
            end
            return 1'b1;
        end
    endfunction

    function automatic int short_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 50) return 0;
            if (r < 95) return $urandom_range(1, 3);
            return $urandom_range(4, 30);
        end
    endfunction

    // Send one box pair, then, if gaps is set, idle for a random gap.
    task automatic send_pair(input box_t a, input box_t b, input bit gaps);
        begin
            boxes.valid <= 1'b1;
            boxes.a_center_x <= a.cx;
            boxes.a_center_y <= a.cy;
            boxes.a_half_width <= a.hw;
            boxes.a_half_height <= a.hh;
            boxes.a_angle_deg <= a.ang;
            boxes.b_center_x <= b.cx;
            boxes.b_center_y <= b.cy;
            boxes.b_half_width <= b.hw;
            boxes.b_half_height <= b.hh;
            boxes.b_angle_deg <= b.ang;
            @(posedge clk);
            while (!boxes.ready)
            begin
                @(posedge clk);
            end
            overlap_q = {overlap_q, boxes_overlap(a, b)};
            if (gaps)
            begin
                repeat (short_gap())
                begin
                    boxes.valid <= 1'b0;
                    @(posedge clk);
                end
            end
        end
    endtask

    function automatic box_t rand_box(int spread, int size);
        box_t b;
        begin
            b.cx = CW'($urandom_range(0, 2 * spread) - spread);
            b.cy = CW'($urandom_range(0, 2 * spread) - spread);
            b.hw = EW'($urandom_range(0, size));
            b.hh = EW'($urandom_range(0, size));
            b.ang = ($urandom_range(0, 9) == 0) ? AGW'($urandom_range(360, 511))
                                                : AGW'($urandom_range(0, 359));
            return b;
        end
    endfunction

    function automatic box_t mk(int cx, int cy, int hw, int hh, int ang);
        box_t b;
        begin
            b.cx = CW'(cx);
            b.cy = CW'(cy);
            b.hw = EW'(hw);
            b.hh = EW'(hh);
            b.ang = AGW'(ang);
            return b;
        end
    endfunction

    task automatic test_directed();
        begin
            send_pair(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0), 1'b1);
            send_pair(mk(-32768, -32768, 16383, 16383, 0),
                      mk(32767, 32767, 16383, 16383, 0), 1'b1);
            send_pair(mk(32767, -32768, 16383, 16383, 359),
                      mk(-32768, 32767, 16383, 16383, 511), 1'b1);
            // touching edges, then a one-unit gap
            send_pair(mk(0, 0, 100, 100, 0), mk(200, 0, 100, 100, 0), 1'b1);
            send_pair(mk(0, 0, 100, 100, 0), mk(201, 0, 100, 100, 0), 1'b1);
            send_pair(mk(0, 0, 100, 100, 90), mk(200, 0, 100, 100, 180), 1'b1);
            send_pair(mk(0, 0, 100, 100, 45), mk(241, 0, 100, 100, 0), 1'b1);
            send_pair(mk(0, 0, 100, 100, 45), mk(242, 0, 100, 100, 0), 1'b1);
            // degenerate boxes
            send_pair(mk(0, 0, 0, 500, 30), mk(10, 10, 400, 0, 300), 1'b1);
            send_pair(mk(0, 0, 0, 0, 10), mk(5000, 0, 10, 10, 0), 1'b1);
            for (int d = 0; d < 512; d += 45)
            begin
                send_pair(mk(0, 0, 300, 50, d), mk(320, 0, 50, 50, 511 - d), 1'b1);
            end
        end
    endtask

    task automatic test_random(int n);
        box_t a;
        box_t b;
        int sz;
        begin
            for (int i = 0; i < n; i++)
            begin
                sz = ($urandom_range(0, 9) == 0) ? 16383 : 2000;
                a = rand_box(32768, sz);
                b = a;
                // bring most pairs close so both outcomes occur
                if ($urandom_range(0, 3) != 0)
                begin
                    b = rand_box(32768, sz);
                    b.cx = a.cx + $signed(16'($urandom_range(0, 2 * sz) - sz));
                    b.cy = a.cy + $signed(16'($urandom_range(0, 2 * sz) - sz));
                end
                else
                begin
                    b = rand_box(32768, sz);
                end
                send_pair(a, b, 1'b1);
            end
        end
    endtask

    // Hold off the result side while requests keep coming, so the pipe fills.
    task automatic test_backpressure();
        begin
            hold_cycles = 0;
            hold_result = 1'b1;
            for (int i = 0; i < 30; i++)
            begin
                send_pair(rand_box(3000, 2000), rand_box(3000, 2000), 1'b0);
            end
            boxes.valid <= 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_result)
        begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 200)
            begin
                hold_result <= 1'b0;
            end
        end
    end

    // Result ready: random stall stretches, mostly short and a few long, long hold when asked.
    always @(posedge clk)
    begin
        if (!rst_n || hold_result)
        begin
            result.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            result.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            result.ready <= 1'b0;
            stall_left <= short_gap();
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    // Check each result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (overlap_q.size() == 0)
            begin
                $error("unexpected result: overlap actual %0d", result.overlap);
                errors++;
            end
            else
            begin
                bit exp_ov;
                exp_ov = overlap_q.pop_front();
                if (result.overlap !== exp_ov)
                begin
                    $error("overlap mismatch: expected %0d actual %0d", exp_ov, result.overlap);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((boxes.valid && boxes.ready) || (result.valid && result.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_result = 1'b0;
        hold_cycles = 0;
        stall_left = 0;
        rst_n = 1'b0;
        boxes.valid = 1'b0;
        boxes.a_center_x = '0;
        boxes.a_center_y = '0;
        boxes.a_half_width = '0;
        boxes.a_half_height = '0;
        boxes.a_angle_deg = '0;
        boxes.b_center_x = '0;
        boxes.b_center_y = '0;
        boxes.b_half_width = '0;
        boxes.b_half_height = '0;
        boxes.b_angle_deg = '0;
        result.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(850);
        boxes.valid <= 1'b0;
        while (overlap_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
